[design/btsv_pkg.sv]
// ----------------------------------------------------------------------------
// btsv_pkg
// Shared types, codes and widths of the beat triggered sample voice.
// ----------------------------------------------------------------------------
package btsv_pkg;

  // Default memory shape
  localparam int unsigned DEF_SAMPLE_DEPTH = 65536;
  localparam int unsigned DEF_SAMPLE_BITS  = 16;

  // Fixed field widths
  localparam int unsigned BEAT_W  = 32;
  localparam int unsigned MIX_W   = 24;
  localparam int unsigned PCM_W   = 16;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned IVL_W   = 24;
  localparam int unsigned SPOS_W  = 17;
  localparam int unsigned POS_W   = 33;
  localparam int unsigned PPOS_W  = 32;
  localparam int unsigned VOL_W   = 9;
  localparam int unsigned CONTR_W = 26;

  // Item function codes
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_DISABLE = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_LOADED   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MUTED    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_VOLUME   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_RATE     = 3'd3;
  localparam logic [CIDX_W-1:0] REG_START    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_END      = 3'd5;
  localparam logic [CIDX_W-1:0] REG_INTERVAL = 3'd6;
  localparam logic [CIDX_W-1:0] REG_DELAY    = 3'd7;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_TRIG,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic wr_mem;
    logic set_supp;
    logic div_start;
    logic trig;
    logic read;
    logic mul;
    logic sum;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

[design/btsv_div.sv]
// ----------------------------------------------------------------------------
// btsv_div
// Restoring serial divider, one quotient bit per cycle; keeps the remainder.
// ----------------------------------------------------------------------------
module btsv_div
  import btsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [BEAT_W-1:0] dividend,
  input  logic [IVL_W-1:0]  divisor,
  output logic              done,
  output logic [IVL_W-1:0]  rem
);

  localparam int unsigned CNT_W = $clog2(BEAT_W);

  logic [BEAT_W-1:0] dvd;
  logic [IVL_W-1:0]  dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [IVL_W:0]    trial;

  // Shift in the next dividend bit
  assign trial = {rem, dvd[BEAT_W-1]};

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(BEAT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend shift
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (trial >= {1'b0, dvs}) begin
        rem <= IVL_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[IVL_W-1:0];
      end
    end
  end

endmodule

[design/btsv_dp.sv]
// ----------------------------------------------------------------------------
// btsv_dp
// Datapath: configuration, sample memories, trigger test, scaling and mixing.
// ----------------------------------------------------------------------------
module btsv_dp
  import btsv_pkg::*;
#(
  parameter int unsigned SAMPLE_DEPTH = DEF_SAMPLE_DEPTH,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [BEAT_W-1:0]        beat_now,
  input  logic [BEAT_W-1:0]        beat_before,
  input  logic signed [MIX_W-1:0]  mix_in_left,
  input  logic signed [MIX_W-1:0]  mix_in_right,
  input  logic [PCM_W-1:0]         wr_addr,
  input  logic signed [PCM_W-1:0]  wr_left,
  input  logic signed [PCM_W-1:0]  wr_right,
  output logic signed [MIX_W-1:0]  out_left,
  output logic signed [MIX_W-1:0]  out_right,
  output logic                     playing
);

  localparam int unsigned AW   = $clog2(SAMPLE_DEPTH);
  localparam int unsigned PW   = SAMPLE_BITS + VOL_W + 1;
  localparam int unsigned SUMW = MIX_W + 3;
  localparam logic signed [SUMW-1:0] MIX_MAX = SUMW'((1 << (MIX_W - 1)) - 1);
  localparam logic signed [SUMW-1:0] MIX_MIN = -SUMW'(1 << (MIX_W - 1));

  // Configuration registers
  logic              loaded;
  logic              muted;
  logic [VOL_W-1:0]  volume;
  logic [IVL_W-1:0]  rate;
  logic [SPOS_W-1:0] start_pos;
  logic [SPOS_W-1:0] end_pos;
  logic [IVL_W-1:0]  interval_ticks;
  logic [IVL_W-1:0]  delay_ticks;

  // Voice state
  logic [PPOS_W-1:0] play_pos;
  logic              waiting;
  logic              suppressed;

  // Per tick work registers
  logic [BEAT_W-1:0]       now_q;
  logic [BEAT_W-1:0]       before_q;
  logic signed [MIX_W-1:0] mix_l_q;
  logic signed [MIX_W-1:0] mix_r_q;
  logic [POS_W-1:0]        pos_work;
  logic                    waiting_work;
  logic signed [SAMPLE_BITS-1:0] rd_l;
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic signed [PW-1:0]    prod_l;
  logic signed [PW-1:0]    prod_r;
  logic signed [MIX_W-1:0] res_l;
  logic signed [MIX_W-1:0] res_r;
  logic                    res_play;

  // Sample memories
  logic [SAMPLE_BITS-1:0] left_mem  [SAMPLE_DEPTH];
  logic [SAMPLE_BITS-1:0] right_mem [SAMPLE_DEPTH];

  // Combinational helpers
  logic [BEAT_W:0]         diff;
  logic [BEAT_W-1:0]       abs_diff;
  logic [IVL_W-1:0]        divisor;
  logic [IVL_W-1:0]        rem;
  logic                    fire;
  logic [POS_W-1:0]        pos_round;
  logic [SPOS_W-1:0]       idx;
  logic [AW-1:0]           rd_addr;
  logic                    wr_in_range;
  logic signed [CONTR_W-1:0] contr_l;
  logic signed [CONTR_W-1:0] contr_r;
  logic signed [SUMW-1:0]  sum_l;
  logic signed [SUMW-1:0]  sum_r;
  logic signed [MIX_W-1:0] sat_l;
  logic signed [MIX_W-1:0] sat_r;
  logic [POS_W-1:0]        pos_adv;
  logic                    stop;
  logic                    add_voice;
  logic                    waiting_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded         <= 1'b0;
      muted          <= 1'b0;
      volume         <= VOL_W'(256);
      rate           <= IVL_W'(65536);
      start_pos      <= '0;
      end_pos        <= SPOS_W'(65536);
      interval_ticks <= IVL_W'(100);
      delay_ticks    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOADED:   loaded         <= cfg_data[0];
        REG_MUTED:    muted          <= cfg_data[0];
        REG_VOLUME:   volume         <= cfg_data[VOL_W-1:0];
        REG_RATE:     rate           <= cfg_data[IVL_W-1:0];
        REG_START:    start_pos      <= cfg_data[SPOS_W-1:0];
        REG_END:      end_pos        <= cfg_data[SPOS_W-1:0];
        REG_INTERVAL: interval_ticks <= cfg_data[IVL_W-1:0];
        REG_DELAY:    delay_ticks    <= cfg_data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Write a sample pair, drop addresses past the memory
  assign wr_in_range = (32'(wr_addr) < 32'(SAMPLE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.wr_mem && wr_in_range) begin
      left_mem[AW'(wr_addr)]  <= SAMPLE_BITS'(wr_left);
      right_mem[AW'(wr_addr)] <= SAMPLE_BITS'(wr_right);
    end
    if (cmd.read) begin
      rd_l <= left_mem[rd_addr];
      rd_r <= right_mem[rd_addr];
    end
  end

  // Hold the tick fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      now_q    <= beat_now;
      before_q <= beat_before;
      mix_l_q  <= mix_in_left;
      mix_r_q  <= mix_in_right;
    end
  end

  // Distance of the beat from the trigger grid offset
  assign diff     = {1'b0, now_q} - (BEAT_W + 1)'(delay_ticks);
  assign abs_diff = diff[BEAT_W] ? BEAT_W'(-diff) : diff[BEAT_W-1:0];
  assign divisor  = (interval_ticks == '0) ? IVL_W'(1) : interval_ticks;

  btsv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (abs_diff),
    .divisor  (divisor),
    .done     (stat.div_done),
    .rem      (rem)
  );

  // Trigger: beat advanced and lands on the grid
  assign fire = loaded && (now_q > before_q) && (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      suppressed <= 1'b0;
    end else if (cmd.set_supp) begin
      suppressed <= 1'b1;
    end else if (cmd.trig && fire && suppressed) begin
      suppressed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trig) begin
      if (fire && !suppressed) begin
        pos_work     <= {start_pos, 16'h0000};
        waiting_work <= 1'b0;
      end else begin
        pos_work     <= {1'b0, play_pos};
        waiting_work <= waiting;
      end
    end
  end

  // Round the position to a sample index and clamp to the memory
  assign pos_round = pos_work + POS_W'(32'h8000);
  assign idx       = pos_round[POS_W-1:16];
  assign rd_addr   = (32'(idx) > 32'(SAMPLE_DEPTH - 1)) ? AW'(SAMPLE_DEPTH - 1) : AW'(idx);

  // Scale by the volume
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_l <= rd_l * $signed({1'b0, volume});
      prod_r <= rd_r * $signed({1'b0, volume});
    end
  end

  // Align the product to the 24-bit mix
  generate
    if (SAMPLE_BITS <= 16) begin : g_up
      assign contr_l = CONTR_W'(prod_l) <<< (16 - SAMPLE_BITS);
      assign contr_r = CONTR_W'(prod_r) <<< (16 - SAMPLE_BITS);
    end else begin : g_down
      logic signed [PW-1:0] sh_l;
      logic signed [PW-1:0] sh_r;
      assign sh_l    = prod_l >>> (SAMPLE_BITS - 16);
      assign sh_r    = prod_r >>> (SAMPLE_BITS - 16);
      assign contr_l = CONTR_W'(sh_l);
      assign contr_r = CONTR_W'(sh_r);
    end
  endgenerate

  // Mix and saturate
  assign sum_l = SUMW'(mix_l_q) + SUMW'(contr_l);
  assign sum_r = SUMW'(mix_r_q) + SUMW'(contr_r);
  assign sat_l = (sum_l > MIX_MAX) ? MIX_W'(MIX_MAX) :
                 (sum_l < MIX_MIN) ? MIX_W'(MIX_MIN) : MIX_W'(sum_l);
  assign sat_r = (sum_r > MIX_MAX) ? MIX_W'(MIX_MAX) :
                 (sum_r < MIX_MIN) ? MIX_W'(MIX_MIN) : MIX_W'(sum_r);

  // Advance the position and test the end
  assign pos_adv      = pos_work + POS_W'(rate);
  assign stop         = (pos_adv >= {end_pos, 16'h0000});
  assign add_voice    = loaded && !waiting_work && !muted;
  assign waiting_next = waiting_work || stop;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      res_l    <= add_voice ? sat_l : mix_l_q;
      res_r    <= add_voice ? sat_r : mix_r_q;
      res_play <= loaded && !waiting_next;
    end
  end

  // Commit the voice state at the end of a tick
  always_ff @(posedge clk) begin
    if (rst) begin
      play_pos <= '0;
      waiting  <= 1'b1;
    end else if (cmd.sum && loaded) begin
      waiting <= waiting_next;
      if (waiting_work) begin
        play_pos <= pos_work[PPOS_W-1:0];
      end else begin
        play_pos <= pos_adv[PPOS_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_left  <= res_l;
      out_right <= res_r;
      playing   <= res_play;
    end
  end

endmodule

[design/btsv_ctrl.sv]
// ----------------------------------------------------------------------------
// btsv_ctrl
// Controller: input handshake, tick sequencing and output valid.
// ----------------------------------------------------------------------------
module btsv_ctrl
  import btsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd,
  input  stat_t      stat
);

  state_t state;
  state_t state_next;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_TICK) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_TRIG;
        end
      end
      ST_TRIG:  state_next = ST_READ;
      ST_READ:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch    = accept && (func == FUNC_TICK);
        cmd.wr_mem   = accept && (func == FUNC_WRITE);
        cmd.set_supp = accept && (func == FUNC_DISABLE);
      end
      ST_LOAD:   cmd.div_start = 1'b1;
      ST_DIV:    ;
      ST_TRIG:   cmd.trig = 1'b1;
      ST_READ:   cmd.read = 1'b1;
      ST_MUL:    cmd.mul = 1'b1;
      ST_SUM:    cmd.sum = 1'b1;
      ST_FINISH: cmd.out_load = slot_free;
      default: ;
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[design/beat_triggered_sample_voice_top.sv]
// ----------------------------------------------------------------------------
// beat_triggered_sample_voice_top
// Stereo sampler voice started on a beat grid. Write and disable items are
// handled in the idle state, which they do not leave. A tick runs through
// the serial remainder unit that tests the beat against the trigger
// interval at one bit per cycle over the 32-bit beat count, then a memory
// read, a scaling multiply and a saturating mix step. The next item is taken
// while a finished result still waits in the output register. Sample memory
// is not cleared at reset; entries read before being written return
// arbitrary data.
// ----------------------------------------------------------------------------
module beat_triggered_sample_voice_top
  import btsv_pkg::*;
#(
  parameter int unsigned SAMPLE_DEPTH = DEF_SAMPLE_DEPTH,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              func,
  input  logic [BEAT_W-1:0]       beat_now,
  input  logic [BEAT_W-1:0]       beat_before,
  input  logic signed [MIX_W-1:0] mix_in_left,
  input  logic signed [MIX_W-1:0] mix_in_right,
  input  logic [PCM_W-1:0]        wr_addr,
  input  logic signed [PCM_W-1:0] wr_left,
  input  logic signed [PCM_W-1:0] wr_right,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [MIX_W-1:0] out_left,
  output logic signed [MIX_W-1:0] out_right,
  output logic                    playing
);

  cmd_t  cmd;
  stat_t stat;

  btsv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  btsv_dp #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .beat_now     (beat_now),
    .beat_before  (beat_before),
    .mix_in_left  (mix_in_left),
    .mix_in_right (mix_in_right),
    .wr_addr      (wr_addr),
    .wr_left      (wr_left),
    .wr_right     (wr_right),
    .out_left     (out_left),
    .out_right    (out_right),
    .playing      (playing)
  );

endmodule
